// ----- rtl/atm_pkg.sv -----
// Shared types and constants for the APB transfer monitor.
// Used by atm_core and apb_transfer_monitor; depends on nothing else.
package atm_pkg;

  localparam int ADDR_WIDTH = 32;
  localparam int DATA_WIDTH = 32;

  localparam logic [31:0] ADDR_MASK =
    (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_WIDTH) - 64'd1);
  localparam logic [31:0] DATA_MASK =
    (DATA_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << DATA_WIDTH) - 64'd1);

  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 64;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_WINDOW_END     = 2'd0,
    CFG_TRANSFER_LIMIT = 2'd1,
    CFG_ERROR_SAMPLED  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [63:0] window_end;
    logic [31:0] transfer_limit;
    logic        error_sampled;
  } cfg_t;

  typedef struct packed {
    logic        first;
    logic        last;
    logic [63:0] sample_time;
    logic        sel;
    logic        enable;
    logic        write_dir;
    logic [31:0] bus_address;
    logic [31:0] bus_wdata;
    logic [31:0] bus_rdata;
    logic        slave_err;
  } sample_t;

  typedef struct packed {
    logic        record_valid;
    logic        rec_write;
    logic [31:0] rec_address;
    logic [31:0] rec_data;
    logic        rec_error;
    logic [63:0] rec_start;
    logic [63:0] rec_end;
    logic [31:0] reads_seen;
    logic [31:0] writes_seen;
    logic [31:0] errors_seen;
    logic [63:0] min_lat;
    logic [63:0] max_lat;
  } record_t;

endpackage

// ----- rtl/apb_transfer_monitor.sv -----
// Top level of the APB transfer monitor: handshake, sample and result registers,
// configuration registers. Depends on atm_pkg and atm_core.
//
// The monitor takes one time-stamped APB sample word per clock while not stalled
// and returns one result word per sample; each word passes through the sample
// register and then the result register. The state update is a single pass of
// combinational logic, so a new sample is taken every cycle as long as the
// result register can move on; a stalled result holds the sample register and
// then the input. Configuration writes take effect at the next clock edge.
module apb_transfer_monitor (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 smp_valid,
  output logic                                 smp_stall,
  input  atm_pkg::sample_t                     smp,
  output logic                                 rpt_valid,
  input  logic                                 rpt_stall,
  output atm_pkg::record_t                     rpt,
  input  logic                                 cfg_we,
  input  logic [atm_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [atm_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
  import atm_pkg::*;

  cfg_t    cfg;
  sample_t smp_q;
  logic    smp_q_valid;
  logic    advance, go;
  record_t core_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_end     <= '0;
      cfg.transfer_limit <= '0;
      cfg.error_sampled  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_END:     cfg.window_end     <= cfg_data;
        CFG_TRANSFER_LIMIT: cfg.transfer_limit <= cfg_data[31:0];
        CFG_ERROR_SAMPLED:  cfg.error_sampled  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The result register moves whenever it is empty or being taken.
  assign advance   = !rpt_valid || !rpt_stall;
  assign go        = smp_q_valid && advance;
  assign smp_stall = smp_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_q_valid <= 1'b0;
    end else if (!smp_stall) begin
      smp_q_valid <= smp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_valid && !smp_stall) begin
      smp_q <= smp;
    end
  end

  atm_core u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .cfg    (cfg),
    .smp    (smp_q),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (advance) begin
      rpt_valid <= smp_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rpt <= core_result;
    end
  end

endmodule

// ----- rtl/atm_core.sv -----
// Transfer tracking state and the per-word update of the APB monitor.
// Depends on atm_pkg; instantiated by apb_transfer_monitor.
module atm_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  atm_pkg::cfg_t    cfg,
  input  atm_pkg::sample_t smp,
  output atm_pkg::record_t result
);
  import atm_pkg::*;

  logic        open_flag, halted;
  logic [63:0] open_start;
  logic        open_write;
  logic [31:0] open_address, open_wdata;
  logic        open_error;
  logic [63:0] prior_time;
  logic [31:0] prior_rdata;
  logic [31:0] read_total, write_total, error_total;
  logic [63:0] lat_low, lat_high;

  logic        open_flag_next, halted_next;
  logic [63:0] open_start_next;
  logic        open_write_next;
  logic [31:0] open_address_next, open_wdata_next;
  logic        open_error_next;
  logic [63:0] prior_time_next;
  logic [31:0] prior_rdata_next;
  logic [31:0] read_total_next, write_total_next, error_total_next;
  logic [63:0] lat_low_next, lat_high_next;

  // State as seen by this word: a first word starts from the cleared state.
  logic        cur_open, cur_halted;
  logic [31:0] cur_reads, cur_writes, cur_errors;
  logic [63:0] cur_low, cur_high;

  logic        active, open_new, close_prior, close_window, do_close;
  logic [31:0] addr, wdata, rdata, end_rdata;
  logic [63:0] close_time, lat;
  logic [32:0] total_sum;

  assign cur_open   = smp.first ? 1'b0 : open_flag;
  assign cur_halted = smp.first ? 1'b0 : halted;
  assign cur_reads  = smp.first ? 32'd0 : read_total;
  assign cur_writes = smp.first ? 32'd0 : write_total;
  assign cur_errors = smp.first ? 32'd0 : error_total;
  assign cur_low    = smp.first ? 64'hFFFF_FFFF_FFFF_FFFF : lat_low;
  assign cur_high   = smp.first ? 64'd0 : lat_high;

  assign active = smp.sel & smp.enable;
  assign addr   = smp.bus_address & ADDR_MASK;
  assign wdata  = smp.bus_wdata & DATA_MASK;
  assign rdata  = smp.bus_rdata & DATA_MASK;

  assign open_new     = !cur_halted && active && !cur_open;
  // A transfer ends either on the first inactive word or at the window end.
  assign close_prior  = !cur_halted && !active && cur_open;
  assign close_window = !cur_halted && active && smp.last;
  assign do_close     = close_prior | close_window;

  always_comb begin
    open_start_next   = open_new ? smp.sample_time : open_start;
    open_write_next   = open_new ? smp.write_dir : open_write;
    open_address_next = open_new ? addr : open_address;
    open_wdata_next   = open_new ? (smp.write_dir ? wdata : 32'd0) : open_wdata;
    open_error_next   = open_new ? (smp.slave_err & cfg.error_sampled) : open_error;
    open_flag_next    = cur_halted ? 1'b0 : (active & !smp.last);
    prior_time_next   = cur_halted ? prior_time : smp.sample_time;
    prior_rdata_next  = cur_halted ? prior_rdata : rdata;
  end

  assign close_time = close_prior ? prior_time : cfg.window_end;
  assign end_rdata  = close_prior ? prior_rdata : rdata;
  assign lat        = (close_time > open_start_next) ? close_time - open_start_next : 64'd0;

  always_comb begin
    read_total_next  = cur_reads;
    write_total_next = cur_writes;
    error_total_next = cur_errors;
    lat_low_next     = cur_low;
    lat_high_next    = cur_high;
    if (do_close) begin
      if (open_write_next) begin
        write_total_next = (cur_writes == 32'hFFFF_FFFF) ? cur_writes : cur_writes + 32'd1;
      end else begin
        read_total_next = (cur_reads == 32'hFFFF_FFFF) ? cur_reads : cur_reads + 32'd1;
      end
      if (open_error_next) begin
        error_total_next = (cur_errors == 32'hFFFF_FFFF) ? cur_errors : cur_errors + 32'd1;
      end
      if (lat < cur_low) begin
        lat_low_next = lat;
      end
      if (lat > cur_high) begin
        lat_high_next = lat;
      end
    end
  end

  assign total_sum   = {1'b0, read_total_next} + {1'b0, write_total_next};
  assign halted_next = cur_halted |
                       (do_close && (cfg.transfer_limit != 32'd0) &&
                        (total_sum >= {1'b0, cfg.transfer_limit}));

  always_comb begin
    result              = '0;
    result.record_valid = do_close;
    if (do_close) begin
      result.rec_write   = open_write_next;
      result.rec_address = open_address_next;
      result.rec_data    = open_write_next ? open_wdata_next : end_rdata;
      result.rec_error   = open_error_next;
      result.rec_start   = open_start_next;
      result.rec_end     = close_time;
    end
    result.reads_seen  = read_total_next;
    result.writes_seen = write_total_next;
    result.errors_seen = error_total_next;
    result.min_lat     = (total_sum == 33'd0) ? 64'd0 : lat_low_next;
    result.max_lat     = lat_high_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_flag   <= 1'b0;
      halted      <= 1'b0;
      read_total  <= '0;
      write_total <= '0;
      error_total <= '0;
      lat_low     <= '1;
      lat_high    <= '0;
    end else if (go) begin
      open_flag   <= open_flag_next;
      halted      <= halted_next;
      read_total  <= read_total_next;
      write_total <= write_total_next;
      error_total <= error_total_next;
      lat_low     <= lat_low_next;
      lat_high    <= lat_high_next;
    end
  end

  // Captured transfer fields are only read while a transfer is open.
  always_ff @(posedge clk) begin
    if (go) begin
      open_start   <= open_start_next;
      open_write   <= open_write_next;
      open_address <= open_address_next;
      open_wdata   <= open_wdata_next;
      open_error   <= open_error_next;
      prior_time   <= prior_time_next;
      prior_rdata  <= prior_rdata_next;
    end
  end

endmodule

// ----- sim/tb_apb_transfer_monitor.sv -----
// Testbench for apb_transfer_monitor: directed and random APB sample streams with
// random idling on both channels, checked word by word against a transfer predictor.
// Depends on atm_pkg and the apb_transfer_monitor RTL.
module tb_apb_transfer_monitor;
  import atm_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 900;
  localparam int PHASE_ITEMS  = 150;
  localparam int HOLD_CYCLES  = 64;

  typedef enum logic [1:0] {BUS_IDLE, BUS_SETUP, BUS_ACCESS} bus_phase_t;

  // Predicts one result word per accepted sample and holds the words still due.
  class transfer_predictor_t;
    record_t     expected_records[$];
    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned records_checked;
    int unsigned halted_samples;

    logic [63:0] window_cfg;
    logic [31:0] limit_cfg;
    logic        err_sample_cfg;

    logic        in_xfer;
    logic        stopped;
    logic [63:0] xfer_start;
    logic        xfer_write;
    logic [31:0] xfer_addr;
    logic [31:0] xfer_wdata;
    logic        xfer_err;
    logic [63:0] last_time;
    logic [31:0] last_rdata;
    logic [31:0] rd_count;
    logic [31:0] wr_count;
    logic [31:0] err_count;
    logic [63:0] lat_min;
    logic [63:0] lat_max;

    function new();
      window_cfg     = '0;
      limit_cfg      = '0;
      err_sample_cfg = 1'b1;
      restart_scan();
    endfunction

    function void restart_scan();
      in_xfer    = 1'b0;
      stopped    = 1'b0;
      xfer_start = '0;
      xfer_write = 1'b0;
      xfer_addr  = '0;
      xfer_wdata = '0;
      xfer_err   = 1'b0;
      last_time  = '0;
      last_rdata = '0;
      rd_count   = '0;
      wr_count   = '0;
      err_count  = '0;
      lat_min    = '1;
      lat_max    = '0;
    endfunction

    function void set_registers(logic [63:0] window, logic [31:0] limit, logic err_on);
      window_cfg     = window;
      limit_cfg      = limit;
      err_sample_cfg = err_on;
    endfunction

    function logic [31:0] count_up(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
    endfunction

    function void finish_transfer(logic [63:0] close_time, logic [31:0] rdata, inout record_t r);
      logic [63:0] lat;
      logic [32:0] done;
      lat = (close_time > xfer_start) ? close_time - xfer_start : 64'd0;
      r.record_valid = 1'b1;
      r.rec_write    = xfer_write;
      r.rec_address  = xfer_addr;
      r.rec_data     = xfer_write ? xfer_wdata : rdata;
      r.rec_error    = xfer_err;
      r.rec_start    = xfer_start;
      r.rec_end      = close_time;
      if (xfer_write) wr_count = count_up(wr_count);
      else rd_count = count_up(rd_count);
      if (xfer_err) err_count = count_up(err_count);
      if (lat < lat_min) lat_min = lat;
      if (lat > lat_max) lat_max = lat;
      in_xfer = 1'b0;
      // The sum is taken one bit wider so that two full counts still compare correctly.
      done = {1'b0, rd_count} + {1'b0, wr_count};
      if (limit_cfg != '0 && done >= {1'b0, limit_cfg}) stopped = 1'b1;
    endfunction

    function void take_sample(sample_t s);
      record_t     r;
      logic        active;
      logic [31:0] addr;
      logic [31:0] wdata;
      logic [31:0] rdata;
      r      = '0;
      active = s.sel & s.enable;
      addr   = s.bus_address & ADDR_MASK;
      wdata  = s.bus_wdata & DATA_MASK;
      rdata  = s.bus_rdata & DATA_MASK;
      if (s.first) restart_scan();
      if (stopped) begin
        halted_samples++;
      end else begin
        if (active) begin
          if (!in_xfer) begin
            in_xfer    = 1'b1;
            xfer_start = s.sample_time;
            xfer_write = s.write_dir;
            xfer_addr  = addr;
            xfer_wdata = s.write_dir ? wdata : 32'd0;
            xfer_err   = s.slave_err & err_sample_cfg;
          end
        end else if (in_xfer) begin
          finish_transfer(last_time, last_rdata, r);
        end
        last_time  = s.sample_time;
        last_rdata = rdata;
        // A transfer still open at the window's last sample ends at the window end.
        if (s.last && in_xfer) finish_transfer(window_cfg, rdata, r);
      end
      r.reads_seen  = rd_count;
      r.writes_seen = wr_count;
      r.errors_seen = err_count;
      r.min_lat     = (rd_count == '0 && wr_count == '0) ? 64'd0 : lat_min;
      r.max_lat     = lat_max;
      expected_records.insert(expected_records.size(), r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_record(record_t got);
      record_t want;
      if (expected_records.size() == 0) begin
        $error("result word arrived with none expected");
        mismatches++;
        return;
      end
      want = expected_records.pop_front();
      words_checked++;
      if (want.record_valid) records_checked++;
      compare_field("record_valid", 64'(want.record_valid), 64'(got.record_valid));
      compare_field("rec_write", 64'(want.rec_write), 64'(got.rec_write));
      compare_field("rec_address", 64'(want.rec_address), 64'(got.rec_address));
      compare_field("rec_data", 64'(want.rec_data), 64'(got.rec_data));
      compare_field("rec_error", 64'(want.rec_error), 64'(got.rec_error));
      compare_field("rec_start", want.rec_start, got.rec_start);
      compare_field("rec_end", want.rec_end, got.rec_end);
      compare_field("reads_seen", 64'(want.reads_seen), 64'(got.reads_seen));
      compare_field("writes_seen", 64'(want.writes_seen), 64'(got.writes_seen));
      compare_field("errors_seen", 64'(want.errors_seen), 64'(got.errors_seen));
      compare_field("min_lat", want.min_lat, got.min_lat);
      compare_field("max_lat", want.max_lat, got.max_lat);
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       smp_valid = 1'b0;
  logic                       smp_stall;
  sample_t                    smp = '0;
  logic                       rpt_valid;
  logic                       rpt_stall = 1'b0;
  record_t                    rpt;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = CFG_WINDOW_END;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  transfer_predictor_t predictor = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int samples_sent   = 0;
  int settings_used  = 0;

  apb_transfer_monitor dut (
    .clk       (clk),
    .rst       (rst),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .smp       (smp),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .rpt       (rpt),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("apb_transfer_monitor: mismatch");
      $finish;
    end
  end

  // Result side: checks each accepted word, then picks the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && rpt_valid && !rpt_stall) predictor.check_record(rpt);
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      rpt_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rpt_stall <= 1'b1;
    end else begin
      rpt_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic sample_t apb_sample(input logic f, input logic l, input logic [63:0] t,
                                         input logic sl, input logic en, input logic wr,
                                         input logic [31:0] a, input logic [31:0] wd,
                                         input logic [31:0] rd, input logic err);
    sample_t s;
    s.first       = f;
    s.last        = l;
    s.sample_time = t;
    s.sel         = sl;
    s.enable      = en;
    s.write_dir   = wr;
    s.bus_address = a;
    s.bus_wdata   = wd;
    s.bus_rdata   = rd;
    s.slave_err   = err;
    return s;
  endfunction

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      smp_valid <= 1'b0;
      @(posedge clk);
    end
    smp       <= s;
    smp_valid <= 1'b1;
    @(posedge clk);
    while (smp_stall) @(posedge clk);
    predictor.take_sample(s);
    samples_sent++;
  endtask

  // Stops offering words until every expected result has come back.
  task automatic drain();
    smp_valid <= 1'b0;
    while (predictor.expected_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [63:0] window, input logic [31:0] limit,
                           input logic err_on);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW_END;
    cfg_data  <= window;
    @(posedge clk);
    // Unused upper bits carry noise; only the register's own width counts.
    cfg_index <= CFG_TRANSFER_LIMIT;
    cfg_data  <= {$urandom, limit};
    @(posedge clk);
    cfg_index <= CFG_ERROR_SAMPLED;
    cfg_data  <= {$urandom, 31'($urandom), err_on};
    @(posedge clk);
    cfg_we <= 1'b0;
    predictor.set_registers(window, limit, err_on);
    settings_used++;
  endtask

  // One scan of well-formed APB phases with random content, salted with noise words.
  task automatic run_scan(input int len, input bit with_first);
    sample_t     s;
    bus_phase_t  bus;
    logic [63:0] t;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic        wr;
    int          k;
    int          pick;
    bus   = BUS_IDLE;
    addr  = $urandom;
    wdata = $urandom;
    wr    = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: t = {$urandom, $urandom};
      1: t = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(2000));
      default: t = 64'($urandom_range(1000));
    endcase
    for (k = 0; k < len; k++) begin
      case (bus)
        BUS_IDLE: bus = ($urandom_range(99) < 75) ? BUS_SETUP : BUS_IDLE;
        BUS_SETUP: bus = BUS_ACCESS;
        default: begin
          pick = $urandom_range(99);
          bus = (pick < 20) ? BUS_ACCESS : (pick < 55) ? BUS_SETUP : BUS_IDLE;
        end
      endcase
      if (bus == BUS_SETUP) begin
        addr  = $urandom;
        wdata = $urandom;
        wr    = 1'($urandom_range(1));
      end
      s = apb_sample(with_first && k == 0,
                     (k == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0),
                     t, bus != BUS_IDLE, bus == BUS_ACCESS, wr, addr, wdata, $urandom,
                     $urandom_range(3) == 0);
      if ($urandom_range(99) < 8) begin
        s.first       = ($urandom_range(9) == 0);
        s.sel         = 1'($urandom_range(1));
        s.enable      = 1'($urandom_range(1));
        s.write_dir   = 1'($urandom_range(1));
        s.bus_address = $urandom;
        s.bus_wdata   = $urandom;
        s.sample_time = {$urandom, $urandom};
      end
      send_sample(s);
      if ($urandom_range(99) < 4) t = t - 64'($urandom_range(50));
      else t = t + 64'($urandom_range(1, 40));
    end
  endtask

  initial begin
    int p;
    int goal;
    logic [63:0] window;
    logic [31:0] limit;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: bus extremes, both directions, error masking, closes at
    // the window end, a time that runs backward, halting on the limit and words
    // that keep coming after the last sample.
    configure(64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b1);
    send_sample(apb_sample(1'b1, 1'b0, 64'd0, 1'b0, 1'b0, 1'b0,
                           32'h0, 32'h0, 32'h0, 1'b0));
    send_sample(apb_sample(1'b0, 1'b0, 64'd10, 1'b1, 1'b0, 1'b1,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0));
    send_sample(apb_sample(1'b0, 1'b0, 64'd20, 1'b1, 1'b1, 1'b1,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1));
    send_sample(apb_sample(1'b0, 1'b0, 64'd30, 1'b0, 1'b0, 1'b0,
                           32'h0, 32'h0, 32'h1234_5678, 1'b0));
    send_sample(apb_sample(1'b0, 1'b0, 64'd40, 1'b1, 1'b0, 1'b0,
                           32'h0, 32'h0, 32'h0, 1'b0));
    send_sample(apb_sample(1'b0, 1'b0, 64'd50, 1'b1, 1'b1, 1'b0,
                           32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0));
    send_sample(apb_sample(1'b0, 1'b0, 64'd60, 1'b1, 1'b1, 1'b0,
                           32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0));
    send_sample(apb_sample(1'b0, 1'b0, 64'd70, 1'b0, 1'b1, 1'b0,
                           32'h0, 32'h0, 32'h0, 1'b0));
    send_sample(apb_sample(1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1,
                           32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0, 1'b0));
    send_sample(apb_sample(1'b0, 1'b0, 64'd5, 1'b1, 1'b1, 1'b1,
                           32'h0, 32'h0, 32'h0, 1'b0));
    send_sample(apb_sample(1'b0, 1'b0, 64'd6, 1'b1, 1'b0, 1'b0,
                           32'h0, 32'h0, 32'h0, 1'b0));
    send_sample(apb_sample(1'b0, 1'b1, 64'd100, 1'b1, 1'b1, 1'b0,
                           32'h0000_1234, 32'h0, 32'hCAFE_F00D, 1'b1));
    send_sample(apb_sample(1'b0, 1'b0, 64'd200, 1'b1, 1'b1, 1'b1,
                           32'h8000_0001, 32'h0F0F_0F0F, 32'h0, 1'b0));
    send_sample(apb_sample(1'b0, 1'b0, 64'd210, 1'b0, 1'b0, 1'b0,
                           32'h0, 32'h0, 32'h0, 1'b0));
    drain();
    configure(64'd0, 32'd2, 1'b0);
    send_sample(apb_sample(1'b1, 1'b0, 64'd1000, 1'b1, 1'b1, 1'b1,
                           32'h0000_0040, 32'hDEAD_BEEF, 32'h0, 1'b1));
    send_sample(apb_sample(1'b0, 1'b0, 64'd1001, 1'b0, 1'b0, 1'b0,
                           32'h0, 32'h0, 32'h0, 1'b0));
    send_sample(apb_sample(1'b0, 1'b1, 64'd1002, 1'b1, 1'b1, 1'b0,
                           32'h0000_0044, 32'h0, 32'h7777_0000, 1'b1));
    send_sample(apb_sample(1'b0, 1'b0, 64'd1003, 1'b1, 1'b1, 1'b1,
                           32'h0000_0048, 32'h1, 32'h2, 1'b0));
    send_sample(apb_sample(1'b0, 1'b0, 64'd1004, 1'b0, 1'b0, 1'b0,
                           32'h0, 32'h0, 32'h0, 1'b0));
    send_sample(apb_sample(1'b1, 1'b1, 64'd1005, 1'b0, 1'b0, 1'b0,
                           32'h0, 32'h0, 32'h0, 1'b0));
    send_sample(apb_sample(1'b0, 1'b0, 64'd1006, 1'b1, 1'b1, 1'b0,
                           32'h0000_004C, 32'h0, 32'h3, 1'b0));

    // Random phases of about PHASE_ITEMS samples each.
    goal = samples_sent + RANDOM_ITEMS;
    p = 0;
    while (samples_sent < goal) begin
      drain();
      case (p % 4)
        0: window = 64'hFFFF_FFFF_FFFF_FFFF;
        1: window = 64'd0;
        2: window = {$urandom, $urandom};
        default: window = 64'($urandom_range(5000));
      endcase
      case (p % 5)
        0: limit = 32'd0;
        1: limit = 32'hFFFF_FFFF;
        2: limit = 32'($urandom_range(2, 6));
        3: limit = 32'd1;
        default: limit = 32'($urandom_range(10, 40));
      endcase
      configure(window, limit, 1'($urandom_range(1)));
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
          // The result side holds off while words keep coming, so the input backs up.
          hold_requests <= hold_requests + 1;
        end
        1: begin
          send_idle_pct = 47;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 47;
        end
        default: begin
          send_idle_pct = 21;
          recv_stall_pct <= 21;
        end
      endcase
      while (samples_sent < goal - RANDOM_ITEMS + (p + 1) * PHASE_ITEMS &&
             samples_sent < goal)
        run_scan($urandom_range(3, 24), $urandom_range(9) != 0);
      p++;
    end

    drain();
    recv_stall_pct <= 0;
    repeat (8) @(posedge clk);
    if (predictor.expected_records.size() != 0)
      $error("%0d result words never arrived", predictor.expected_records.size());
    $display("Sent %0d samples under %0d register settings; %0d result words checked,",
             samples_sent, settings_used, predictor.words_checked);
    $display("%0d of them transfer records, %0d samples ignored while halted.",
             predictor.records_checked, predictor.halted_samples);
    if (predictor.mismatches == 0 && predictor.expected_records.size() == 0) begin
      $display("apb_transfer_monitor: match");
    end else begin
      $display("apb_transfer_monitor: mismatch");
    end
    $finish;
  end

endmodule
